// ----- src/lfms_pkg.sv -----
// ============================================================================
// lfms_pkg
// Shared types and constants for the line follower mode and steering block.
// ============================================================================
package lfms_pkg;

    typedef enum logic [2:0] {
        MODE_BOOT      = 3'd0,
        MODE_BOOT_ALM  = 3'd1,
        MODE_READY     = 3'd2,
        MODE_READY_ALM = 3'd3,
        MODE_RUN       = 3'd4,
        MODE_RUN_ALM   = 3'd5,
        MODE_SEARCH    = 3'd6
    } mode_t;

    // APB register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_COOLDOWN   = 3'd0,
        REG_LEFT_THR   = 3'd1,
        REG_RIGHT_THR  = 3'd2,
        REG_MIN_SPEED  = 3'd3,
        REG_SEARCH_HI  = 3'd4,
        REG_SEARCH_LO  = 3'd5
    } reg_idx_t;

    localparam logic [7:0] STEER_CENTER = 8'h80;
    localparam logic [7:0] STEER_MIN    = 8'h01;
    localparam logic [7:0] STEER_MAX    = 8'hFE;

    localparam logic [7:0] RST_COOLDOWN  = 8'd50;
    localparam logic [3:0] RST_LEFT_THR  = 4'h2;
    localparam logic [3:0] RST_RIGHT_THR = 4'h4;
    localparam logic [7:0] RST_MIN_SPEED = 8'h00;
    localparam logic [7:0] RST_SEARCH_HI = 8'hE0;
    localparam logic [7:0] RST_SEARCH_LO = 8'h1F;

    // run speed by switch bits 5:4
    function automatic logic [7:0] run_speed(input logic [1:0] sel);
        logic [7:0] s;
        case (sel)
            2'd0:    s = 8'h90;
            2'd1:    s = 8'hB0;
            2'd2:    s = 8'hD0;
            default: s = 8'hF0;
        endcase
        return s;
    endfunction

    // floor(n * 10 / 3) for a 4-bit setting
    function automatic logic [5:0] hold_of(input logic [3:0] n);
        logic [5:0] h;
        case (n)
            4'd0:    h = 6'd0;
            4'd1:    h = 6'd3;
            4'd2:    h = 6'd6;
            4'd3:    h = 6'd10;
            4'd4:    h = 6'd13;
            4'd5:    h = 6'd16;
            4'd6:    h = 6'd20;
            4'd7:    h = 6'd23;
            4'd8:    h = 6'd26;
            4'd9:    h = 6'd30;
            4'd10:   h = 6'd33;
            4'd11:   h = 6'd36;
            4'd12:   h = 6'd40;
            4'd13:   h = 6'd43;
            4'd14:   h = 6'd46;
            default: h = 6'd50;
        endcase
        return h;
    endfunction

endpackage

// ----- src/line_follower_mode_and_steering.sv -----
// ============================================================================
// line_follower_mode_and_steering
// Vehicle mode sequencer and steering controller, one control tick per item.
// ============================================================================
// Data path: an accepted input is held in the input register, then one pass
//   of logic loads the result register, which drives m_axis.
// Throughput: 1 tick per cycle unless m_axis stalls; the tick state is set in
//   the same pass that loads the result register, so the next tick sees it.
// Reset (rst_n low, async): mode boot, steering 128, all counters and flags
//   cleared, configuration registers to their defaults, both stages empty.
module line_follower_mode_and_steering
    import lfms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] button_event, [8:1] switches, [16:9] line_sensors,
    // [17] motor_stopped, [25:18] steering_feedback, [31:26] zero
    input  logic [31:0] s_axis_tdata,
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] speed_cmd, [15:8] steering_drive, [18:16] vehicle_state,
    // [24:19] hold_time, [31:25] zero
    output logic [31:0] m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] cooldown_ticks_reg;
    logic [3:0] left_thr_reg;
    logic [3:0] right_thr_reg;
    logic [7:0] min_speed_reg;
    logic [7:0] search_hi_reg;
    logic [7:0] search_lo_reg;

    logic       cfg_wr;
    reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_ticks_reg <= RST_COOLDOWN;
            left_thr_reg       <= RST_LEFT_THR;
            right_thr_reg      <= RST_RIGHT_THR;
            min_speed_reg      <= RST_MIN_SPEED;
            search_hi_reg      <= RST_SEARCH_HI;
            search_lo_reg      <= RST_SEARCH_LO;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_COOLDOWN:  cooldown_ticks_reg <= pwdata[7:0];
                REG_LEFT_THR:  left_thr_reg       <= pwdata[3:0];
                REG_RIGHT_THR: right_thr_reg      <= pwdata[3:0];
                REG_MIN_SPEED: min_speed_reg      <= pwdata[7:0];
                REG_SEARCH_HI: search_hi_reg      <= pwdata[7:0];
                REG_SEARCH_LO: search_lo_reg      <= pwdata[7:0];
                default: ;   // unmapped addresses are ignored
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_COOLDOWN:  prdata = {24'd0, cooldown_ticks_reg};
            REG_LEFT_THR:  prdata = {28'd0, left_thr_reg};
            REG_RIGHT_THR: prdata = {28'd0, right_thr_reg};
            REG_MIN_SPEED: prdata = {24'd0, min_speed_reg};
            REG_SEARCH_HI: prdata = {24'd0, search_hi_reg};
            REG_SEARCH_LO: prdata = {24'd0, search_lo_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register -> result register.
    // The input stage refills in the same cycle it drains.
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic [25:0] in_data_reg;
    logic        out_valid_reg;
    logic [24:0] out_data_reg;
    logic        advance;

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_data_reg <= s_axis_tdata[25:0];
    end

    // ------------------------------------------------------------------
    // Tick state
    // ------------------------------------------------------------------
    mode_t      mode_reg,     mode_next;
    logic       pending_reg,  pending_next;
    logic [7:0] cooldown_reg, cooldown_next;
    logic [7:0] steer_reg,    steer_next;
    logic       sweep_up_reg, sweep_up_next;
    logic       parity_reg;
    logic [5:0] hold_reg,     hold_next;
    logic [7:0] speed_next;

    // unpacked tick fields
    logic       t_button;
    logic [7:0] t_switches;
    logic [7:0] t_sensors;
    logic       t_stopped;
    logic [7:0] t_feedback;

    assign t_button   = in_data_reg[0];
    assign t_switches = in_data_reg[8:1];
    assign t_sensors  = in_data_reg[16:9];
    assign t_stopped  = in_data_reg[17];
    assign t_feedback = in_data_reg[25:18];

    // intermediate values of the tick
    logic       press;
    logic       dark;
    mode_t      mode_a;       // after the mode rules
    logic [7:0] cd_load;
    logic       step_dn;
    logic       step_up;
    logic [7:0] steer_step;   // +/-1 result, unclamped (never wraps: 1..254 in)
    logic [7:0] steer_clamp;

    always_comb
    begin
        press = pending_reg | t_button;
        dark  = (t_sensors == 8'd0);

        // mode rules, applied in order
        mode_a = mode_reg;
        if (mode_a == MODE_BOOT || mode_a == MODE_BOOT_ALM)
            mode_a = press ? MODE_BOOT_ALM : MODE_READY;
        if (mode_a == MODE_RUN_ALM && t_stopped)
            mode_a = MODE_READY;
        if (mode_a == MODE_READY && press && dark)
            mode_a = MODE_READY_ALM;
        if (mode_a == MODE_READY_ALM && !dark)
            mode_a = MODE_READY;

        pending_next = press;
        cd_load      = cooldown_reg;
        if (press && cooldown_reg == 8'd0)
        begin
            // accepted press: clear latch, restart cooldown, toggle ready/run
            pending_next = 1'b0;
            cd_load      = cooldown_ticks_reg;
            if (mode_a == MODE_READY)
                mode_a = MODE_RUN;
            else if (mode_a == MODE_RUN)
                mode_a = MODE_READY;
        end
        cooldown_next = (cd_load != 8'd0) ? cd_load - 8'd1 : cd_load;

        speed_next = (mode_a == MODE_RUN) ? run_speed(t_switches[5:4]) : min_speed_reg;

        // steering step for run and search
        step_dn = 1'b0;
        step_up = 1'b0;
        case (mode_a)
            MODE_RUN:
            begin
                step_dn = ~parity_reg & (t_sensors[3:0] > left_thr_reg);
                step_up = ~parity_reg & (t_sensors[7:4] > right_thr_reg);
            end
            MODE_SEARCH:
            begin
                step_dn = ~sweep_up_reg;
                step_up = sweep_up_reg;
            end
            default: ;
        endcase

        if (step_up && !step_dn)
            steer_step = steer_reg + 8'd1;
        else if (step_dn && !step_up)
            steer_step = steer_reg - 8'd1;
        else
            steer_step = steer_reg;

        if (steer_step > STEER_MAX)
            steer_clamp = STEER_MAX;
        else if (steer_step < STEER_MIN)
            steer_clamp = STEER_MIN;
        else
            steer_clamp = steer_step;

        mode_next     = mode_a;
        steer_next    = steer_reg;
        sweep_up_next = sweep_up_reg;
        case (mode_a)
            MODE_READY:
            begin
                // one step toward center per tick
                if (steer_reg < STEER_CENTER)
                    steer_next = steer_reg + 8'd1;
                else if (steer_reg > STEER_CENTER)
                    steer_next = steer_reg - 8'd1;
            end
            MODE_RUN:
            begin
                steer_next    = steer_clamp;
                sweep_up_next = (steer_clamp < STEER_CENTER);
                if (dark)
                    mode_next = MODE_SEARCH;
            end
            MODE_SEARCH:
            begin
                steer_next = steer_clamp;
                if (!dark)
                    mode_next = MODE_RUN;
                else if ((sweep_up_reg && t_feedback >= search_hi_reg) ||
                         (!sweep_up_reg && t_feedback <= search_lo_reg))
                    mode_next = MODE_RUN_ALM;
            end
            default: ;   // alarm and boot modes hold the steering
        endcase

        hold_next = (mode_next == MODE_READY) ? hold_of(t_switches[3:0]) : hold_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_BOOT;
            pending_reg  <= 1'b0;
            cooldown_reg <= 8'd0;
            steer_reg    <= STEER_CENTER;
            sweep_up_reg <= 1'b0;
            parity_reg   <= 1'b0;
            hold_reg     <= 6'd0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            pending_reg  <= pending_next;
            cooldown_reg <= cooldown_next;
            steer_reg    <= steer_next;
            sweep_up_reg <= sweep_up_next;
            parity_reg   <= ~parity_reg;
            hold_reg     <= hold_next;
        end
    end

    // result register: payload only, qualified by out_valid_reg
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {hold_next, mode_next, steer_next, speed_next};
    end

endmodule

// ----- src/lfms_checker.sv -----
// ============================================================================
// lfms_checker
// Port-level checks on the result stream of the mode and steering block.
// ============================================================================
module lfms_checker
    import lfms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // steering stays inside 1..254
    a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:8] != 8'h00 && m_axis_tdata[15:8] != 8'hFF)
        else $error("steering out of range");

    // mode code 7 is unreachable
    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[18:16] != 3'd7)
        else $error("unreachable mode code");

    // hold time never exceeds 50
    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[24:19] <= 6'd50)
        else $error("hold time out of range");

    // boot is left on the first tick, so no result ever reports it
    a_no_boot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[18:16] != MODE_BOOT)
        else $error("boot mode in a result");

endmodule

bind line_follower_mode_and_steering lfms_checker u_lfms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
